/* sv/gdmf_pkg.sv */
`default_nettype none

package gdmf_pkg;

    localparam int PIX_W          = 8;
    localparam int CFG_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int COORD_W        = 12;
    localparam int ROW_CNT_W      = 12;
    localparam int MAX_HEIGHT     = 4096;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HALF_X_DEF = 2;
    localparam int MAX_HALF_Y_DEF = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT  = 2'd3;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd4032;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd3024;
    localparam logic [1:0]       RST_HALF_WIDTH   = 2'd2;
    localparam logic [1:0]       RST_HALF_HEIGHT  = 2'd2;

endpackage

`default_nettype wire

/* sv/grayscale_dilation_max_filter_core.sv */
// Grayscale dilation (windowed maximum) over a raster-order pixel stream.
// Pixels enter on the s_ channel (valid/ready), one transaction per pixel,
// with s_frame_start marking column 0 of row 0. For every centre pixel whose
// whole window lies inside the image, one transaction leaves on the m_
// channel carrying the window maximum, the centre coordinates and a flag on
// the transaction caused by the last pixel of the frame. Border centres
// produce nothing. Image size and window radii are set through the cfg_
// write port, which must only be used while the block is idle.
// An accepted pixel waits in the stage-1 registers; its result is registered
// into the output register once that is free. One pixel is accepted every
// cycle while the output is not stalled; the rate is set by the single
// line-store memory, read for a column as a pixel is accepted and written
// back as it leaves stage 1, forwarded when read again at once (one-pixel-wide images).
// If the receiver stalls, the result waits in the output register and one
// more pixel may still enter; after that s_ready stays low until m_ready.
// Reset clears the position counters and loads the default registers; the
// line store is not cleared and holds rows only once they have been written.
`default_nettype none

module grayscale_dilation_max_filter_core
    import gdmf_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HALF_X = MAX_HALF_X_DEF,
    parameter int MAX_HALF_Y = MAX_HALF_Y_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [PIX_W-1:0]     s_pixel,
    input  wire logic                 s_frame_start,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic      [PIX_W-1:0]     m_max_value,
    output logic      [COORD_W-1:0]   m_centre_x,
    output logic      [COORD_W-1:0]   m_centre_y,
    output logic                      m_frame_last
);

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int STORE_ROWS = 2 * MAX_HALF_Y;
    localparam int WIN_COLS   = 2 * MAX_HALF_X + 1;
    localparam int HX_W       = $clog2(MAX_HALF_X + 1);
    localparam int HY_W       = $clog2(MAX_HALF_Y + 1);
    localparam int LS_W       = PIX_W * STORE_ROWS;
    localparam int ROW_EXT_W  = ROW_CNT_W + 1;

    // Configuration registers.
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [1:0]       half_width_reg;
    logic [1:0]       half_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            half_width_reg   <= RST_HALF_WIDTH;
            half_height_reg  <= RST_HALF_HEIGHT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                REG_HALF_WIDTH:   half_width_reg   <= cfg_wdata[1:0];
                REG_HALF_HEIGHT:  half_height_reg  <= cfg_wdata[1:0];
            endcase
        end
    end

    logic [COL_W:0]     w_eff;
    logic [ROW_EXT_W-1:0] h_eff;
    logic [HX_W-1:0]    hx_eff;
    logic [HY_W-1:0]    hy_eff;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = (COL_W + 1)'(1);
        end else if (int'(image_width_reg) > MAX_WIDTH) begin
            w_eff = (COL_W + 1)'(MAX_WIDTH);
        end else begin
            w_eff = (COL_W + 1)'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_eff = ROW_EXT_W'(1);
        end else if (int'(image_height_reg) > MAX_HEIGHT) begin
            h_eff = ROW_EXT_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_EXT_W'(image_height_reg);
        end
        if (int'(half_width_reg) > MAX_HALF_X) begin
            hx_eff = HX_W'(MAX_HALF_X);
        end else begin
            hx_eff = HX_W'(half_width_reg);
        end
        if (int'(half_height_reg) > MAX_HALF_Y) begin
            hy_eff = HY_W'(MAX_HALF_Y);
        end else begin
            hy_eff = HY_W'(half_height_reg);
        end
    end

    // Handshake control.
    logic s1_valid_reg, s1_valid_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;
    logic s1_adv;
    logic accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // Position counters and per-pixel decisions.
    logic [COL_W-1:0]     col_cnt_reg, col_cnt_next;
    logic [ROW_CNT_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W:0]       cc;
    logic [ROW_EXT_W-1:0] rc;
    logic [COL_W-1:0]     cur_x;
    logic [ROW_CNT_W-1:0] cur_y;
    logic [COL_W:0]       x_inc;
    logic [ROW_EXT_W-1:0] y_inc;
    logic                 cur_emit;
    logic                 cur_last;
    logic [COORD_W-1:0]   cur_cx;
    logic [COORD_W-1:0]   cur_cy;

    always_comb begin
        cc = s_frame_start ? '0 : {1'b0, col_cnt_reg};
        rc = s_frame_start ? '0 : {1'b0, row_cnt_reg};
        if (cc >= w_eff) begin
            cc = '0;
            rc = rc + ROW_EXT_W'(1);
        end
        if (rc >= h_eff) begin
            rc = '0;
        end
        cur_x = COL_W'(cc);
        cur_y = ROW_CNT_W'(rc);

        x_inc = {1'b0, cur_x} + (COL_W + 1)'(1);
        y_inc = {1'b0, cur_y} + ROW_EXT_W'(1);
        if (x_inc >= w_eff) begin
            col_cnt_next = '0;
            row_cnt_next = (y_inc >= h_eff) ? '0 : ROW_CNT_W'(y_inc);
        end else begin
            col_cnt_next = COL_W'(x_inc);
            row_cnt_next = cur_y;
        end

        cur_emit = ({1'b0, cur_x} >= (COL_W + 1)'({hx_eff, 1'b0}))
                && ({1'b0, cur_y} >= ROW_EXT_W'({hy_eff, 1'b0}));
        cur_last = ({1'b0, cur_x} == w_eff - (COL_W + 1)'(1))
                && ({1'b0, cur_y} == h_eff - ROW_EXT_W'(1));
        cur_cx   = COORD_W'(cur_x - COL_W'(hx_eff));
        cur_cy   = COORD_W'(cur_y - ROW_CNT_W'(hy_eff));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // Line store: one word per column holding the previous rows.
    logic [COL_W-1:0]   s1_x_reg;
    logic [PIX_W-1:0]   s1_pix_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [COORD_W-1:0] s1_cx_reg;
    logic [COORD_W-1:0] s1_cy_reg;
    logic               fwd_sel_reg;
    logic [LS_W-1:0]    fwd_data_reg;
    logic [LS_W-1:0]    ls_rd_data;
    logic [LS_W-1:0]    ls_col;
    logic [LS_W-1:0]    ls_wr_data;

    gdmf_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (s1_adv),
        .wr_addr (s1_x_reg),
        .wr_data (ls_wr_data),
        .rd_en   (accept),
        .rd_addr (cur_x),
        .rd_data (ls_rd_data)
    );

    assign ls_col = fwd_sel_reg ? fwd_data_reg : ls_rd_data;

    generate
        if (STORE_ROWS > 1) begin : g_shift
            assign ls_wr_data = {ls_col[LS_W-PIX_W-1:0], s1_pix_reg};
        end else begin : g_single
            assign ls_wr_data = s1_pix_reg;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_x_reg    <= cur_x;
            s1_pix_reg  <= s_pixel;
            s1_emit_reg <= cur_emit;
            s1_last_reg <= cur_last;
            s1_cx_reg   <= cur_cx;
            s1_cy_reg   <= cur_cy;
            fwd_sel_reg <= s1_adv && (s1_x_reg == cur_x);
            fwd_data_reg <= ls_wr_data;
        end
    end

    // Column maximum and horizontal window.
    logic [PIX_W-1:0] win_reg [WIN_COLS];
    logic [PIX_W-1:0] col_max;
    logic [PIX_W-1:0] win_max;

    always_comb begin
        col_max = s1_pix_reg;
        for (int k = 0; k < STORE_ROWS; k++) begin
            if ((k < 2 * int'(hy_eff)) && (ls_col[k*PIX_W +: PIX_W] > col_max)) begin
                col_max = ls_col[k*PIX_W +: PIX_W];
            end
        end
        win_max = col_max;
        for (int k = 1; k < WIN_COLS; k++) begin
            if ((k <= 2 * int'(hx_eff)) && (win_reg[k-1] > win_max)) begin
                win_max = win_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            win_reg[0] <= col_max;
            for (int k = 1; k < WIN_COLS; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    // Stage and output valid flags.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = s1_adv && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    logic [PIX_W-1:0]   max_value_reg;
    logic [COORD_W-1:0] centre_x_reg;
    logic [COORD_W-1:0] centre_y_reg;
    logic               frame_last_reg;

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            max_value_reg  <= win_max;
            centre_x_reg   <= s1_cx_reg;
            centre_y_reg   <= s1_cy_reg;
            frame_last_reg <= s1_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_max_value  = max_value_reg;
    assign m_centre_x   = centre_x_reg;
    assign m_centre_y   = centre_y_reg;
    assign m_frame_last = frame_last_reg;

endmodule

`default_nettype wire

/* sv/gdmf_ram.sv */
`default_nettype none

module gdmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdmf_pkg::*;

    localparam int LINE_ROWS    = 2 * MAX_HALF_Y_DEF;
    localparam int WIN_COLS     = 2 * MAX_HALF_X_DEF + 1;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 440;
    localparam int LARGE_ITEMS  = 48;

    typedef struct packed {
        logic [PIX_W-1:0]   max_value;
        logic [COORD_W-1:0] centre_x;
        logic [COORD_W-1:0] centre_y;
        logic               frame_last;
    } dilation_result_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel       = '0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [PIX_W-1:0]     m_max_value;
    logic [COORD_W-1:0]   m_centre_x;
    logic [COORD_W-1:0]   m_centre_y;
    logic                 m_frame_last;

    // Shadow of the block's state, kept in step with every accepted pixel.
    bit   [PIX_W-1:0]     line_mem [LINE_ROWS][MAX_WIDTH_DEF];
    bit   [PIX_W-1:0]     col_peaks [WIN_COLS];
    int unsigned          col_pos = 0;
    int unsigned          row_pos = 0;
    logic [CFG_W-1:0]     cfg_width  = RST_IMAGE_WIDTH;
    logic [CFG_W-1:0]     cfg_height = RST_IMAGE_HEIGHT;
    logic [1:0]           cfg_half_x = RST_HALF_WIDTH;
    logic [1:0]           cfg_half_y = RST_HALF_HEIGHT;

    dilation_result_t     pending_windows [$];
    int unsigned          mismatch_count  = 0;
    int unsigned          burst_left      = 0;
    logic [7:0]           rx_cycle        = '0;
    rx_mode_t             rx_mode         = RX_OPEN;

    grayscale_dilation_max_filter_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_max_value   (m_max_value),
        .m_centre_x    (m_centre_x),
        .m_centre_y    (m_centre_y),
        .m_frame_last  (m_frame_last)
    );

    always #5 aclk = ~aclk;

    function automatic int unsigned clamp_size(input int unsigned reg_value,
                                               input int unsigned limit);
        if (reg_value == 0)
            return 1;
        return (reg_value > limit) ? limit : reg_value;
    endfunction

    function automatic void predict_dilation(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned      w;
        int unsigned      h;
        int unsigned      hx;
        int unsigned      hy;
        int unsigned      x;
        int unsigned      y;
        logic [PIX_W-1:0] col_peak;
        logic [PIX_W-1:0] win_peak;
        dilation_result_t res;
        w  = clamp_size(cfg_width, MAX_WIDTH_DEF);
        h  = clamp_size(cfg_height, MAX_HEIGHT);
        hx = (cfg_half_x > MAX_HALF_X_DEF) ? MAX_HALF_X_DEF : cfg_half_x;
        hy = (cfg_half_y > MAX_HALF_Y_DEF) ? MAX_HALF_Y_DEF : cfg_half_y;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h)
            row_pos = 0;
        x = col_pos;
        y = row_pos;

        col_peak = pix;
        for (int k = 0; k < 2 * hy; k++)
            if (line_mem[k][x] > col_peak)
                col_peak = line_mem[k][x];
        for (int k = LINE_ROWS - 1; k > 0; k--)
            line_mem[k][x] = line_mem[k-1][x];
        line_mem[0][x] = pix;

        for (int k = WIN_COLS - 1; k > 0; k--)
            col_peaks[k] = col_peaks[k-1];
        col_peaks[0] = col_peak;
        win_peak = '0;
        for (int k = 0; k <= 2 * hx; k++)
            if (col_peaks[k] > win_peak)
                win_peak = col_peaks[k];

        if (y >= 2 * hy && x >= 2 * hx) begin
            res.max_value  = win_peak;
            res.centre_x   = COORD_W'(x - hx);
            res.centre_y   = COORD_W'(y - hy);
            res.frame_last = (x == w - 1) && (y == h - 1);
            pending_windows.push_back(res);
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            predict_dilation(s_pixel, s_frame_start);
    end

    always @(posedge aclk) begin : check_results
        dilation_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_windows.size() == 0) begin
                note_mismatch($sformatf("unexpected transaction: max=%0d x=%0d y=%0d last=%0b",
                                        m_max_value, m_centre_x, m_centre_y, m_frame_last));
            end else begin
                want = pending_windows.pop_front();
                if (m_max_value !== want.max_value || m_centre_x !== want.centre_x ||
                    m_centre_y !== want.centre_y || m_frame_last !== want.frame_last) begin
                    note_mismatch($sformatf({"mismatch: expected max=%0d x=%0d y=%0d last=%0b,",
                                             " got max=%0d x=%0d y=%0d last=%0b"},
                                            want.max_value, want.centre_x, want.centre_y,
                                            want.frame_last, m_max_value, m_centre_x,
                                            m_centre_y, m_frame_last));
                end
            end
        end
    end

    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 8'd1;
        if (rx_cycle[6:0] == 7'd0)
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
        case (rx_mode)
            RX_OPEN:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= ($urandom_range(0, 9) < 7);
            RX_PERIODIC: m_ready <= (rx_cycle[2:0] != 3'd5) && (rx_cycle[2:0] != 3'd6);
            default:     m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Presents one pixel, waits for the edge that accepts it, then may pause the stream.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned gap;
        s_valid       <= 1'b1;
        s_pixel       <= pix;
        s_frame_start <= fs;
        do
            @(posedge aclk);
        while (!s_ready);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        if (s_valid)
            s_valid <= 1'b0;
        while (pending_windows.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = value;
            REG_IMAGE_HEIGHT: cfg_height = value;
            REG_HALF_WIDTH:   cfg_half_x = value[1:0];
            default:          cfg_half_y = value[1:0];
        endcase
        @(posedge aclk);
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                                input logic [1:0] hx, input logic [1:0] hy);
        wait_idle();
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
        write_register(REG_HALF_WIDTH, CFG_W'(hx));
        write_register(REG_HALF_HEIGHT, CFG_W'(hy));
        cfg_wr_en <= 1'b0;
    endtask

    // Border pixels of the default 4032 x 3024 frame give no transactions.
    task automatic test_default_geometry();
        for (int p = 0; p < 16; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0);
    endtask

    task automatic test_single_window();
        set_geometry(13'd5, 13'd5, 2'd2, 2'd2);
        for (int p = 0; p < 25; p++)
            send_pixel((p == 24) ? 8'd255 : PIX_W'(p * 9), p == 0);
    endtask

    task automatic test_frame_wrap();
        for (int p = 0; p < 25; p++)
            send_pixel(PIX_W'($urandom_range(0, 254)), 1'b0);
    endtask

    task automatic test_oversized_window();
        set_geometry(13'd4, 13'd3, 2'd3, 2'd1);
        for (int p = 0; p < 12; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), p == 0);
    endtask

    task automatic test_frame_restart();
        set_geometry(13'd6, 13'd4, 2'd1, 2'd1);
        for (int p = 0; p < 9; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), p == 0);
        for (int p = 0; p < 24; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), p == 0);
    endtask

    task automatic test_zero_radius();
        logic [PIX_W-1:0] values [6];
        values = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd127, 8'd254};
        set_geometry(13'd3, 13'd2, 2'd0, 2'd0);
        for (int p = 0; p < 6; p++)
            send_pixel(values[p], p == 0);
    endtask

    // Register values beyond the limits saturate; zero acts as one.
    task automatic test_largest_sizes();
        set_geometry(13'd8191, 13'd1, 2'd2, 2'd0);
        for (int p = 0; p < LARGE_ITEMS; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), p == 0);
        set_geometry(13'd0, 13'd8191, 2'd0, 2'd2);
        for (int p = 0; p < LARGE_ITEMS; p++)
            send_pixel(PIX_W'($urandom_range(0, 255)), p == 0);
    endtask

    // Every phase opens with a frame start, so no window ever reaches line store
    // columns left over from an earlier geometry.
    task automatic test_random_frames();
        int unsigned      sent;
        int unsigned      w_reg;
        int unsigned      h_reg;
        int unsigned      frame_px;
        int unsigned      frames;
        int unsigned      cut;
        logic             fs;
        logic [PIX_W-1:0] pix;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       w_reg = 0;
                1:       w_reg = 1;
                default: w_reg = $urandom_range(2, 20);
            endcase
            case ($urandom_range(0, 9))
                0:       h_reg = 0;
                1:       h_reg = 1;
                default: h_reg = $urandom_range(2, 10);
            endcase
            set_geometry(CFG_W'(w_reg), CFG_W'(h_reg),
                         2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
            frame_px = clamp_size(w_reg, MAX_WIDTH_DEF) * clamp_size(h_reg, MAX_HEIGHT);
            frames   = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                cut = (f == frames - 1 && $urandom_range(0, 4) == 0)
                      ? $urandom_range(1, frame_px) : frame_px;
                for (int p = 0; p < cut && sent < RANDOM_ITEMS; p++) begin
                    fs = (p == 0) && (f == 0 || $urandom_range(0, 1) == 1);
                    if ($urandom_range(0, 49) == 0)
                        fs = 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        pix = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
                    else
                        pix = PIX_W'($urandom_range(0, 255));
                    send_pixel(pix, fs);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_geometry();
        test_single_window();
        test_frame_wrap();
        test_oversized_window();
        test_frame_restart();
        test_zero_radius();
        test_largest_sizes();
        test_random_frames();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* grayscale_dilation_max_filter_core.f */
sv/gdmf_pkg.sv
sv/gdmf_ram.sv
sv/grayscale_dilation_max_filter_core.sv
tb/tb.sv
